>>> rtl/core/ppd_pkg.sv
// Shared types and constants for the pixel detector packet decoder.
package ppd_pkg;

   // Chunk header signature, bytes 0 to 2 of the header word.
   localparam logic [7:0] HDR_BYTE0 = 8'h54;
   localparam logic [7:0] HDR_BYTE1 = 8'h50;
   localparam logic [7:0] HDR_BYTE2 = 8'h58;

   // Packet type codes taken from the top byte of a data word.
   localparam logic [7:0] TOP_TDC    = 8'h6F;
   localparam logic [3:0] NIBBLE_HIT = 4'hB;

   // Chip layout codes; any other code is the quad layout.
   localparam logic [7:0] LAYOUT_SINGLE = 8'd0;
   localparam logic [7:0] LAYOUT_DOUBLE = 8'd1;
   localparam logic [7:0] LAYOUT_TRIPLE = 8'd2;

   // Layout offsets.
   localparam logic [9:0] OFFSET_SINGLE = 10'd260;
   localparam logic [9:0] FLIP_WIDE     = 10'd515;
   localparam logic [9:0] FLIP_NARROW   = 10'd255;

   localparam int unsigned WORDS_LEFT_W = 13;
   localparam int unsigned STAMP_W      = 30;

   // One decoded hit.
   typedef struct packed {
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [9:0]  over_threshold;
      logic [13:0] arrival_coarse;
      logic [3:0]  arrival_fine;
      logic [31:0] flight_time;
      logic [29:0] full_time;
   } result_type;

endpackage

>>> rtl/core/ppd_decoder.sv
// Chunk tracking state and per-word hit decode.
module ppd_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [63:0]         word,
   output logic                hit,
   output ppd_pkg::result_type result
);

   logic [ppd_pkg::WORDS_LEFT_W-1:0] words_left_ff, words_left_in;
   logic [7:0]                       layout_ff, layout_in;
   logic [ppd_pkg::STAMP_W-1:0]      stamp_ff, stamp_in;

   logic        in_chunk;
   logic        is_header;
   logic        is_tdc;
   logic        is_hit;
   logic [7:0]  top;
   logic [15:0] pa;
   logic [7:0]  col;
   logic [7:0]  row;
   logic [29:0] full;

   // Word classification.
   assign top       = word[63:56];
   assign in_chunk  = (words_left_ff != '0);
   assign is_header = !in_chunk && (word[7:0] == ppd_pkg::HDR_BYTE0)
                      && (word[15:8] == ppd_pkg::HDR_BYTE1)
                      && (word[23:16] == ppd_pkg::HDR_BYTE2);
   assign is_tdc    = in_chunk && (top == ppd_pkg::TOP_TDC);
   assign is_hit    = in_chunk && (top[7:4] == ppd_pkg::NIBBLE_HIT);

   // Pixel address split; the column and row sums never carry, so they pack.
   assign pa  = word[59:44];
   assign col = {pa[15:9], pa[2]};
   assign row = {pa[8:3], pa[1:0]};

   // Spider time and coarse arrival occupy disjoint bits of the full time.
   assign full = {word[15:0], word[43:30]};

   // Chunk state update for a consumed word.
   always_comb begin
      words_left_in = words_left_ff;
      layout_in     = layout_ff;
      stamp_in      = stamp_ff;
      if (step) begin
         if (in_chunk) begin
            words_left_in = words_left_ff - ppd_pkg::WORDS_LEFT_W'(1);
            if (is_tdc) begin
               stamp_in = word[41:12];
            end
         end else if (is_header) begin
            words_left_in = word[63:51];
            layout_in     = word[39:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_left_ff <= '0;
         layout_ff     <= '0;
         stamp_ff      <= '0;
      end else begin
         words_left_ff <= words_left_in;
         layout_ff     <= layout_in;
         stamp_ff      <= stamp_in;
      end
   end

   // Hit fields with the layout adjustment.
   always_comb begin
      result.over_threshold = word[29:20];
      result.arrival_coarse = word[43:30];
      result.arrival_fine   = word[19:16];
      result.full_time      = full;
      result.flight_time    = {2'b00, full} - {2'b00, stamp_ff};
      case (layout_ff)
         ppd_pkg::LAYOUT_SINGLE: begin
            result.pos_x = {2'b00, col} + ppd_pkg::OFFSET_SINGLE;
            result.pos_y = {2'b00, row};
         end
         ppd_pkg::LAYOUT_DOUBLE: begin
            result.pos_x = ppd_pkg::FLIP_WIDE - {2'b00, col};
            result.pos_y = ppd_pkg::FLIP_WIDE - {2'b00, row};
         end
         ppd_pkg::LAYOUT_TRIPLE: begin
            result.pos_x = ppd_pkg::FLIP_NARROW - {2'b00, col};
            result.pos_y = ppd_pkg::FLIP_WIDE - {2'b00, row};
         end
         default: begin
            result.pos_x = {2'b00, col};
            result.pos_y = {2'b00, row};
         end
      endcase
   end

   assign hit = step && is_hit;

endmodule

>>> rtl/core/pixel_detector_packet_decoder_top.sv
// Top level of the pixel detector packet decoder.
//
// The req channel carries one raw 64-bit packet per transaction, byte 0 in
// the low bits. A header word opens a chunk and sets the chip layout; words
// inside the chunk are decoded, TDC words update the stored stamp, and each
// hit word yields exactly one transaction on the rsp channel. Other words
// give no result.
// Pipeline: an input register, then the decode and chunk state update, then
// a result register; a hit word passes through both registers to rsp.
// Throughput is one packet per cycle while rsp is not stalled, set by the
// single decode stage that also owns the chunk state.
// When the receiver stalls, the result register holds and the input register
// still takes one more packet; req_ready then drops until rsp drains.
// A synchronous reset empties both registers, closes any open chunk and
// clears the layout code and the TDC stamp to zero.
module pixel_detector_packet_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pos_x,
   output logic [9:0]  rsp_pos_y,
   output logic [9:0]  rsp_over_threshold,
   output logic [13:0] rsp_arrival_coarse,
   output logic [3:0]  rsp_arrival_fine,
   output logic [31:0] rsp_flight_time,
   output logic [29:0] rsp_full_time
);

   logic                s1_valid_ff, s1_valid_in;
   logic [63:0]         s1_word_ff, s1_word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ppd_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                advance;
   logic                hit;
   ppd_pkg::result_type result;

   // The input stage moves on when the result register is free or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_word_in  = req_word;
      end
   end

   ppd_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (s1_word_ff),
      .hit    (hit),
      .result (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = hit;
      end
      if (hit) begin
         rsp_data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_data_ff.pos_x;
   assign rsp_pos_y          = rsp_data_ff.pos_y;
   assign rsp_over_threshold = rsp_data_ff.over_threshold;
   assign rsp_arrival_coarse = rsp_data_ff.arrival_coarse;
   assign rsp_arrival_fine   = rsp_data_ff.arrival_fine;
   assign rsp_flight_time    = rsp_data_ff.flight_time;
   assign rsp_full_time      = rsp_data_ff.full_time;

   // A held input word must not change while the output side is blocked.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("input stage changed while stalled");

   // Taking a new word while the input stage is full needs it to move on.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && s1_valid_ff |-> advance)
      else $error("input stage overwritten");

   // A hit is only produced for a word being consumed.
   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      hit |-> advance)
      else $error("hit without a consumed word");

   // Adjusted pixel positions stay inside the assembled sensor area.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.pos_x <= 10'd515) && (rsp_data_ff.pos_y <= 10'd515))
      else $error("pixel position out of range");

   // The full time carries the coarse arrival in its low bits.
   a_full_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.full_time[13:0] == rsp_data_ff.arrival_coarse)
      else $error("full time does not match coarse arrival");

endmodule
